// File: src/lfpd_pkg.sv
package lfpd_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int NUM_SENSORS = 5;
  localparam int ERR_W       = 12;
  localparam int PID_W       = 22;
  localparam int ABS_W       = 20;
  localparam int MAC_X_W     = 22;
  localparam int MAC_Y_W     = 16;
  localparam int MAC_R_W     = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_THRESHOLD = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN      = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_SPEED      = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BEND_SPEED     = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_START    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_TRIM     = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SERVO_MID      = 4'd7;

  typedef struct packed {
    logic [9:0] line_threshold;
    logic [7:0] prop_gain;
    logic [7:0] deriv_gain;
    logic [7:0] top_speed;
    logic [7:0] bend_speed;
    logic [7:0] brake_start;
    logic [5:0] wheel_trim;
    logic [7:0] servo_mid;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    line_threshold: 10'd740,
    prop_gain:      8'd16,
    deriv_gain:     8'd55,
    top_speed:      8'd240,
    bend_speed:     8'd90,
    brake_start:    8'd25,
    wheel_trim:     6'd9,
    servo_mid:      8'd90
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROP,
    ST_DERIV,
    ST_ABS,
    ST_BRAKE,
    ST_BASE,
    ST_ADJ,
    ST_MOTOR_A,
    ST_MOTOR_B,
    ST_OUT
  } state_t;

  typedef logic [1:0] turn_t;
  localparam turn_t TURN_NONE = 2'd0;
  localparam turn_t TURN_POS  = 2'd1;
  localparam turn_t TURN_NEG  = 2'd3;

  localparam logic signed [ERR_W-1:0] ERR_LOST_POS = 12'sd896;
  localparam logic signed [ERR_W-1:0] ERR_LOST_NEG = -12'sd896;
  localparam logic signed [ERR_W-1:0] TURN_HYST    = 12'sd26;

  // position error indexed by the on-line mask, bit 0 = far left
  localparam logic signed [ERR_W-1:0] ERR_TABLE [32] = '{
    12'sd0,    12'sd896,  12'sd384,  12'sd640,
    12'sd0,    12'sd448,  12'sd192,  12'sd426,
    -12'sd384, 12'sd256,  12'sd0,    12'sd298,
    -12'sd192, 12'sd170,  12'sd0,    12'sd224,
    -12'sd896, 12'sd0,    -12'sd256, 12'sd128,
    -12'sd448, 12'sd0,    -12'sd170, 12'sd96,
    -12'sd640, -12'sd128, -12'sd298, 12'sd0,
    -12'sd426, -12'sd96,  -12'sd224, 12'sd0
  };

  // divide by 35 as multiply by 2^20/35 rounded up, exact below 35*256
  localparam logic signed [MAC_Y_W-1:0] RECIP_35   = 16'sd29960;
  localparam logic [13:0]               BRAKE_DMAX = 14'd8960;
  localparam logic signed [MAC_Y_W-1:0] ADJ_GAIN   = 16'sd819;
  localparam logic signed [MAC_Y_W-1:0] K_SLOW     = -16'sd77;
  localparam logic signed [MAC_Y_W-1:0] K_FAST     = 16'sd307;

  localparam logic signed [23:0] ANGLE_MIN = 24'sd35;
  localparam logic signed [23:0] ANGLE_MAX = 24'sd145;

endpackage

// File: src/line_follower_pd_steering.sv
// PD line-follower steering. One sample set is taken when s_tready is high; the
// block then works on it through the states PROP to OUT and takes no new set
// meanwhile. The steering figure comes from a single shared multiply-add unit that
// is stepped through the P and D products, the brake factor, the brake blend, the
// turn adjustment and the two wheel speeds in turn. The result sits in an output
// register, so the next set may be taken while the last result still waits.
// Configuration writes are taken in any cycle and should only be made while the
// block is idle.
module line_follower_pd_steering (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // far_left_sample, near_left_sample, centre_sample, near_right_sample,
  // far_right_sample, zero pad
  input  logic [lfpd_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // steer_angle, motor_a_reverse, motor_a_duty, motor_b_reverse, motor_b_duty,
  // zero pad
  output logic [lfpd_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lfpd_pkg::cfg_t   cfg;
  lfpd_pkg::state_t state, state_next;

  logic signed [lfpd_pkg::ERR_W-1:0]   err, prev_err, err_new;
  lfpd_pkg::turn_t                     turn_mem, turn_next;
  logic signed [lfpd_pkg::PID_W-1:0]   acc, pid;
  logic [lfpd_pkg::ABS_W-1:0]          absq;
  logic [7:0]                          angle, base;
  logic [8:0]                          bf;
  logic [13:0]                         adj;
  logic signed [15:0]                  speed_a, speed_b;

  logic signed [lfpd_pkg::MAC_X_W-1:0] mac_x;
  logic signed [lfpd_pkg::MAC_Y_W-1:0] mac_y;
  logic signed [lfpd_pkg::MAC_R_W-1:0] mac_z, mac_r;
  logic signed [23:0]                  mac_q;

  logic                                accept, out_load;
  logic [lfpd_pkg::NUM_SENSORS-1:0]    on_line;
  logic signed [12:0]                  diff;
  logic signed [lfpd_pkg::PID_W-1:0]   pid_mag;
  logic signed [31:0]                  angle_sum;
  logic signed [23:0]                  angle_q;
  logic [7:0]                          angle_clamped;
  logic [15:0]                         brake_level;
  logic                                brake_on;
  logic [lfpd_pkg::ABS_W-1:0]          d_raw;
  logic [13:0]                         d_clamp;
  logic signed [8:0]                   speed_gap;
  logic [9:0]                          base_a;
  logic signed [9:0]                   base_b;
  logic                                pid_pos;
  logic [8:0]                          word_a, word_b;

  function automatic logic signed [23:0] div256_trunc(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v + (v[31] ? 32'sd255 : 32'sd0);
    return $signed(t[31:8]);
  endfunction

  function automatic logic [8:0] motor_word(input logic signed [15:0] s);
    logic [15:0] mag;
    mag = s[15] ? 16'(-s) : 16'(s);
    return {s[15], (mag > 16'd255) ? 8'hFF : mag[7:0]};
  endfunction

  lfpd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lfpd_mac u_mac (
    .x (mac_x),
    .y (mac_y),
    .z (mac_z),
    .r (mac_r)
  );

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid & s_tready;

  // sensing and lost-line handling
  always_comb begin
    for (int i = 0; i < lfpd_pkg::NUM_SENSORS; i++) begin
      on_line[i] = s_tdata[i*lfpd_pkg::SAMPLE_W +: lfpd_pkg::SAMPLE_W] < cfg.line_threshold;
    end
    turn_next = turn_mem;
    if (on_line == '0) begin
      case (turn_mem)
        lfpd_pkg::TURN_POS: err_new = lfpd_pkg::ERR_LOST_POS;
        lfpd_pkg::TURN_NEG: err_new = lfpd_pkg::ERR_LOST_NEG;
        default:            err_new = '0;
      endcase
    end else begin
      err_new = lfpd_pkg::ERR_TABLE[on_line];
      if (err_new > lfpd_pkg::TURN_HYST) begin
        turn_next = lfpd_pkg::TURN_POS;
      end else if (err_new < -lfpd_pkg::TURN_HYST) begin
        turn_next = lfpd_pkg::TURN_NEG;
      end
    end
  end

  assign diff          = $signed({err[11], err}) - $signed({prev_err[11], prev_err});
  assign pid_mag       = pid[lfpd_pkg::PID_W-1] ? -pid : pid;
  assign angle_sum     = 32'(pid) + $signed({16'h0, cfg.servo_mid, 8'h00});
  assign angle_q       = div256_trunc(angle_sum);
  assign angle_clamped = (angle_q < lfpd_pkg::ANGLE_MIN) ? lfpd_pkg::ANGLE_MIN[7:0] :
                         (angle_q > lfpd_pkg::ANGLE_MAX) ? lfpd_pkg::ANGLE_MAX[7:0] :
                         angle_q[7:0];
  assign brake_level   = {cfg.brake_start, 8'h00};
  assign brake_on      = absq > lfpd_pkg::ABS_W'(brake_level);
  assign d_raw         = absq - lfpd_pkg::ABS_W'(brake_level);
  assign d_clamp       = !brake_on ? 14'd0 :
                         (d_raw > lfpd_pkg::ABS_W'(lfpd_pkg::BRAKE_DMAX)) ?
                         lfpd_pkg::BRAKE_DMAX : d_raw[13:0];
  assign speed_gap     = $signed({1'b0, cfg.bend_speed}) - $signed({1'b0, cfg.top_speed});
  assign base_a        = {2'b00, base} + {4'b0000, cfg.wheel_trim};
  assign base_b        = $signed({2'b00, base}) - $signed({4'b0000, cfg.wheel_trim});
  assign pid_pos       = !pid[lfpd_pkg::PID_W-1] && (pid != '0);
  assign mac_q         = div256_trunc(mac_r);
  assign word_a        = motor_word(speed_a);
  assign word_b        = motor_word(speed_b);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lfpd_pkg::ST_IDLE:    if (s_tvalid) state_next = lfpd_pkg::ST_PROP;
      lfpd_pkg::ST_PROP:    state_next = lfpd_pkg::ST_DERIV;
      lfpd_pkg::ST_DERIV:   state_next = lfpd_pkg::ST_ABS;
      lfpd_pkg::ST_ABS:     state_next = lfpd_pkg::ST_BRAKE;
      lfpd_pkg::ST_BRAKE:   state_next = lfpd_pkg::ST_BASE;
      lfpd_pkg::ST_BASE:    state_next = lfpd_pkg::ST_ADJ;
      lfpd_pkg::ST_ADJ:     state_next = lfpd_pkg::ST_MOTOR_A;
      lfpd_pkg::ST_MOTOR_A: state_next = lfpd_pkg::ST_MOTOR_B;
      lfpd_pkg::ST_MOTOR_B: state_next = lfpd_pkg::ST_OUT;
      lfpd_pkg::ST_OUT:     if (!m_tvalid || m_tready) state_next = lfpd_pkg::ST_IDLE;
      default:              state_next = lfpd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and shared unit operands
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    mac_x    = '0;
    mac_y    = '0;
    mac_z    = '0;
    case (state)
      lfpd_pkg::ST_IDLE: s_tready = 1'b1;
      lfpd_pkg::ST_PROP: begin
        mac_x = lfpd_pkg::MAC_X_W'(err);
        mac_y = $signed({8'h00, cfg.prop_gain});
      end
      lfpd_pkg::ST_DERIV: begin
        mac_x = lfpd_pkg::MAC_X_W'(diff);
        mac_y = $signed({8'h00, cfg.deriv_gain});
        mac_z = lfpd_pkg::MAC_R_W'(acc);
      end
      lfpd_pkg::ST_BRAKE: begin
        mac_x = $signed({8'h00, d_clamp});
        mac_y = lfpd_pkg::RECIP_35;
      end
      lfpd_pkg::ST_BASE: begin
        mac_x = lfpd_pkg::MAC_X_W'(speed_gap);
        mac_y = $signed({7'h00, bf});
        mac_z = $signed({16'h0000, cfg.top_speed, 8'h00});
      end
      lfpd_pkg::ST_ADJ: begin
        mac_x = $signed({2'b00, absq});
        mac_y = lfpd_pkg::ADJ_GAIN;
      end
      lfpd_pkg::ST_MOTOR_A: begin
        mac_x = $signed({8'h00, adj});
        mac_y = pid_pos ? lfpd_pkg::K_SLOW : lfpd_pkg::K_FAST;
        mac_z = $signed({14'h0000, base_a, 8'h00});
      end
      lfpd_pkg::ST_MOTOR_B: begin
        mac_x = $signed({8'h00, adj});
        mac_y = pid_pos ? lfpd_pkg::K_FAST : lfpd_pkg::K_SLOW;
        mac_z = $signed({{14{base_b[9]}}, base_b, 8'h00});
      end
      lfpd_pkg::ST_OUT: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lfpd_pkg::ST_IDLE;
      prev_err <= '0;
      turn_mem <= lfpd_pkg::TURN_NONE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        turn_mem <= turn_next;
      end
      if (state == lfpd_pkg::ST_DERIV) begin
        prev_err <= err;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err <= err_new;
    end
    case (state)
      lfpd_pkg::ST_PROP:    acc     <= mac_r[lfpd_pkg::PID_W-1:0];
      lfpd_pkg::ST_DERIV:   pid     <= mac_r[lfpd_pkg::PID_W-1:0];
      lfpd_pkg::ST_ABS: begin
        absq  <= pid_mag[lfpd_pkg::ABS_W-1:0];
        angle <= angle_clamped;
      end
      lfpd_pkg::ST_BRAKE:   bf      <= mac_r[28:20];
      lfpd_pkg::ST_BASE:    base    <= mac_r[15:8];
      lfpd_pkg::ST_ADJ:     adj     <= mac_r[29:16];
      lfpd_pkg::ST_MOTOR_A: speed_a <= mac_q[15:0];
      lfpd_pkg::ST_MOTOR_B: speed_b <= mac_q[15:0];
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= {6'h00, word_b[7:0], word_b[8], word_a[7:0], word_a[8], angle};
    end
  end

endmodule

// File: src/lfpd_cfg.sv
module lfpd_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [lfpd_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]    wr_data,
  output lfpd_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= lfpd_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        lfpd_pkg::REG_LINE_THRESHOLD: cfg.line_threshold <= wr_data;
        lfpd_pkg::REG_PROP_GAIN:      cfg.prop_gain      <= wr_data[7:0];
        lfpd_pkg::REG_DERIV_GAIN:     cfg.deriv_gain     <= wr_data[7:0];
        lfpd_pkg::REG_TOP_SPEED:      cfg.top_speed      <= wr_data[7:0];
        lfpd_pkg::REG_BEND_SPEED:     cfg.bend_speed     <= wr_data[7:0];
        lfpd_pkg::REG_BRAKE_START:    cfg.brake_start    <= wr_data[7:0];
        lfpd_pkg::REG_WHEEL_TRIM:     cfg.wheel_trim     <= wr_data[5:0];
        lfpd_pkg::REG_SERVO_MID:      cfg.servo_mid      <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/lfpd_mac.sv
module lfpd_mac (
  input  logic signed [lfpd_pkg::MAC_X_W-1:0] x,
  input  logic signed [lfpd_pkg::MAC_Y_W-1:0] y,
  input  logic signed [lfpd_pkg::MAC_R_W-1:0] z,
  output logic signed [lfpd_pkg::MAC_R_W-1:0] r
);

  logic signed [lfpd_pkg::MAC_X_W+lfpd_pkg::MAC_Y_W-1:0] prod;

  assign prod = x * y;
  assign r    = $signed(prod[lfpd_pkg::MAC_R_W-1:0]) + z;

endmodule

// File: src/lfpd_checker.sv
module lfpd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [lfpd_pkg::OUT_DATA_W-1:0]   m_tdata
);

  // output transfer holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  // a taken sample set keeps the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] >= 8'd35 && m_tdata[7:0] <= 8'd145)
    else $error("steer angle out of range");

  // reverse means a nonzero negative speed
  a_reverse_duty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[8] || m_tdata[16:9] != 8'd0) &&
                 (!m_tdata[17] || m_tdata[25:18] != 8'd0))
    else $error("reverse with zero duty");

endmodule

bind line_follower_pd_steering lfpd_checker u_lfpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
